/* sv/tcg_pkg.sv */
package tcg_pkg;

    localparam int TEMP_W  = 11;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 3;
    localparam int NUM_PTS = 6;
    localparam int IDX_W   = 3;
    localparam int PCT_W   = 7;
    localparam int OFF_W   = 5;
    localparam int SEG_W   = 3;
    localparam int PROD_W  = PCT_W + CHAN_W;

    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [NUM_PTS-1:0][COLOR_W-1:0] color_bank_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_COLOR_AT_30  = 3'd0,
        CFG_COLOR_AT_50  = 3'd1,
        CFG_COLOR_AT_70  = 3'd2,
        CFG_COLOR_AT_80  = 3'd3,
        CFG_COLOR_AT_90  = 3'd4,
        CFG_COLOR_AT_100 = 3'd5
    } cfg_idx_t;

    localparam logic signed [TEMP_W-1:0] BP_T [NUM_PTS] = '{
        11'sd30, 11'sd50, 11'sd70, 11'sd80, 11'sd90, 11'sd100
    };

    localparam color_bank_t RESET_COLORS = {
        24'hFF0000, 24'hD3435C, 24'hFFFF00, 24'h23C48E, 24'hADD8E6, 24'hFFFFFF
    };

    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } lane_ld_t;

endpackage

/* sv/tcg_temp_if.sv */
interface tcg_temp_if
    import tcg_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink (input valid, input temperature, output ready);
endinterface

/* sv/tcg_color_if.sv */
interface tcg_color_if
    import tcg_pkg::*;
();
    logic   valid;
    logic   ready;
    color_t rgb_color;

    modport source (output valid, output rgb_color, input ready);
    modport sink (input valid, input rgb_color, output ready);
endinterface

/* sv/tcg_cfg_if.sv */
interface tcg_cfg_if
    import tcg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    color_t           data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/tcg_cfg_regs.sv */
module tcg_cfg_regs
    import tcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tcg_cfg_if.sink     cfg,
    output color_bank_t colors
);

    color_bank_t bank_reg;

    assign cfg.ready = 1'b1;
    assign colors    = bank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= RESET_COLORS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_COLOR_AT_30:  bank_reg[0] <= cfg.data;
                CFG_COLOR_AT_50:  bank_reg[1] <= cfg.data;
                CFG_COLOR_AT_70:  bank_reg[2] <= cfg.data;
                CFG_COLOR_AT_80:  bank_reg[3] <= cfg.data;
                CFG_COLOR_AT_90:  bank_reg[4] <= cfg.data;
                CFG_COLOR_AT_100: bank_reg[5] <= cfg.data;
                default:          bank_reg    <= bank_reg;
            endcase
        end
    end

endmodule

/* sv/tcg_seg_decode.sv */
module tcg_seg_decode
    import tcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     ld1,
    input  logic signed [TEMP_W-1:0] temperature,
    input  color_bank_t              colors,
    output logic [PCT_W-1:0]         pct,
    output color_t                   color_lo,
    output color_t                   color_hi
);

    logic [SEG_W-1:0]         seg;
    logic [SEG_W-1:0]         seg_up;
    logic signed [TEMP_W-1:0] off_full;
    logic [OFF_W-1:0]         off;
    logic [PCT_W-1:0]         pct_next;
    color_t                   lo_next;
    color_t                   hi_next;
    logic [PCT_W-1:0]         pct_reg;
    color_t                   lo_reg;
    color_t                   hi_reg;

    always_comb
    begin
        if (temperature >= BP_T[4])
        begin
            seg = 3'd4;
        end
        else if (temperature >= BP_T[3])
        begin
            seg = 3'd3;
        end
        else if (temperature >= BP_T[2])
        begin
            seg = 3'd2;
        end
        else if (temperature >= BP_T[1])
        begin
            seg = 3'd1;
        end
        else
        begin
            seg = 3'd0;
        end
        seg_up   = seg + 3'd1;
        off_full = temperature - BP_T[seg];
        off      = off_full[OFF_W-1:0];

        if (temperature < BP_T[0])
        begin
            pct_next = '0;
            lo_next  = colors[0];
            hi_next  = colors[0];
        end
        else if (temperature >= BP_T[NUM_PTS-1])
        begin
            pct_next = '0;
            lo_next  = colors[NUM_PTS-1];
            hi_next  = colors[NUM_PTS-1];
        end
        else
        begin
            if (seg < 3'd2)
            begin
                pct_next = PCT_W'(off) * 7'd5;
            end
            else
            begin
                pct_next = PCT_W'(off) * 7'd10;
            end
            lo_next = colors[seg];
            hi_next = colors[seg_up];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            pct_reg <= pct_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
        end
    end

    assign pct      = pct_reg;
    assign color_lo = lo_reg;
    assign color_hi = hi_reg;

endmodule

/* sv/tcg_blend_lane.sv */
module tcg_blend_lane
    import tcg_pkg::*;
(
    input  logic              clk,
    input  lane_ld_t          ld,
    input  logic [PCT_W-1:0]  pct,
    input  logic [CHAN_W-1:0] chan_lo,
    input  logic [CHAN_W-1:0] chan_hi,
    output logic [CHAN_W-1:0] chan_out
);

    logic [CHAN_W:0]    diff;
    logic               neg;
    logic [CHAN_W:0]    mag_full;
    logic [CHAN_W-1:0]  mag;
    logic [PROD_W-1:0]  prod_next;
    logic [CHAN_W-1:0]  a2_reg;
    logic               neg2_reg;
    logic [PROD_W-1:0]  prod2_reg;

    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [CHAN_W-1:0]         q_next;
    logic [CHAN_W-1:0]         a3_reg;
    logic                      neg3_reg;
    logic [CHAN_W-1:0]         q3_reg;

    logic [CHAN_W:0]   q_ext;
    logic [CHAN_W:0]   sum;
    logic [CHAN_W-1:0] out4_reg;

    always_comb
    begin
        diff      = {1'b0, chan_hi} - {1'b0, chan_lo};
        neg       = diff[CHAN_W];
        mag_full  = neg ? (~diff + 9'd1) : diff;
        mag       = mag_full[CHAN_W-1:0];
        prod_next = PROD_W'(pct) * PROD_W'(mag);
    end

    // The quotient by 100 comes from a reciprocal product, exact for every
    // product a lane can form.
    always_comb
    begin
        scaled = (PROD_W+RECIP_W)'(prod2_reg) * (PROD_W+RECIP_W)'(RECIP_100);
        q_next = scaled[RECIP_SHIFT +: CHAN_W];
    end

    always_comb
    begin
        q_ext = {1'b0, q3_reg};
        sum   = {1'b0, a3_reg} + (neg3_reg ? (~q_ext + 9'd1) : q_ext);
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld2)
        begin
            a2_reg    <= chan_lo;
            neg2_reg  <= neg;
            prod2_reg <= prod_next;
        end
        if (ld.ld3)
        begin
            a3_reg   <= a2_reg;
            neg3_reg <= neg2_reg;
            q3_reg   <= q_next;
        end
        if (ld.ld4)
        begin
            out4_reg <= sum[CHAN_W-1:0];
        end
    end

    assign chan_out = out4_reg;

endmodule

/* sv/temperature_color_gradient.sv */
// Maps a signed temperature in whole degrees to a 24-bit RGB color on a
// piecewise-linear gradient with breakpoints at 30, 50, 70, 80, 90 and 100
// degrees, whose colors are set through the configuration port. The block
// takes one request per cycle unless a stall at the output backs up to the
// input. Its four register stages are the segment decode, the percent times
// channel difference product, the reciprocal product that divides by 100,
// and the final add into the output register. Each stage holds its item
// while the next stage is full and cannot move on, so a stall at the output
// backs up through the pipeline without dropping or repeating a request.
module temperature_color_gradient
    import tcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tcg_temp_if.sink    temp_in,
    tcg_color_if.source color_out,
    tcg_cfg_if.sink     cfg
);

    color_bank_t       colors;
    logic [PCT_W-1:0]  pct1;
    color_t            lo1;
    color_t            hi1;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              v4_reg;
    logic              v1_next;
    logic              v2_next;
    logic              v3_next;
    logic              v4_next;
    logic              rdy1;
    logic              rdy2;
    logic              rdy3;
    logic              rdy4;
    lane_ld_t          lane_ld;
    logic [NUM_CH-1:0][CHAN_W-1:0] chan_out;

    tcg_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .colors (colors)
    );

    always_comb
    begin
        rdy4    = !v4_reg || color_out.ready;
        rdy3    = !v3_reg || rdy4;
        rdy2    = !v2_reg || rdy3;
        rdy1    = !v1_reg || rdy2;
        v1_next = rdy1 ? temp_in.valid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        v4_next = rdy4 ? v3_reg : v4_reg;
        lane_ld = '{ld2: rdy2, ld3: rdy3, ld4: rdy4};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    tcg_seg_decode u_seg_decode (
        .clk         (clk),
        .ld1         (rdy1),
        .temperature (temp_in.temperature),
        .colors      (colors),
        .pct         (pct1),
        .color_lo    (lo1),
        .color_hi    (hi1)
    );

    for (genvar k = 0; k < NUM_CH; k++)
    begin : g_lane
        tcg_blend_lane u_lane (
            .clk      (clk),
            .ld       (lane_ld),
            .pct      (pct1),
            .chan_lo  (lo1[CHAN_W*k +: CHAN_W]),
            .chan_hi  (hi1[CHAN_W*k +: CHAN_W]),
            .chan_out (chan_out[k])
        );
    end

    assign temp_in.ready       = rdy1;
    assign color_out.valid     = v4_reg;
    assign color_out.rgb_color = chan_out;

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !temp_in.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !color_out.ready))
        else $error("input refused while the pipeline has room");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v4_reg) |-> $past(v3_reg))
        else $error("result appeared without an item behind it");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !rdy2) |=> (v1_reg && $stable(pct1) && $stable(lo1) && $stable(hi1)))
        else $error("stalled first stage changed its item");

endmodule
